// File: rtl/core/gpo_pkg.sv
// Shared types and constants for the GPIO pin owner controller.
`timescale 1ns / 1ps
`default_nettype none

package gpo_pkg;

    localparam int MAX_OWNERS = 8;
    localparam int NUM_PORTS  = 4;

    localparam int SLOT_COUNT = (MAX_OWNERS > 8) ? 8 : MAX_OWNERS;
    localparam int PORT_COUNT = (NUM_PORTS > 4) ? 4 : ((NUM_PORTS < 1) ? 1 : NUM_PORTS);

    localparam int PIN_W     = 32;
    localparam int PORT_W    = 8;
    localparam int SLOT_W    = 3;
    localparam int NOTIFY_W  = 8;
    localparam int PORTS_MAX = 4;

    localparam logic [PIN_W-1:0] PRESENT_PINS =
        PIN_W'((64'd1 << (PORT_W * PORT_COUNT)) - 64'd1);

    typedef enum logic [3:0] {
        FN_CLAIM      = 4'd0,
        FN_RELEASE    = 4'd1,
        FN_INPUT      = 4'd2,
        FN_OUTPUT     = 4'd3,
        FN_HIGH       = 4'd4,
        FN_LOW        = 4'd5,
        FN_TOGGLE     = 4'd6,
        FN_WRITE      = 4'd7,
        FN_READ_IN    = 4'd8,
        FN_READ_DRIVE = 4'd9,
        FN_TRISTATE   = 4'd10,
        FN_SAMPLE     = 4'd11,
        FN_OWNED      = 4'd12
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TAKEN   = 2'd1,
        ST_NO_SLOT = 2'd2
    } status_t;

    // One accepted operation as seen by the state modules
    typedef struct packed {
        logic              accept;
        func_t             func;
        logic [SLOT_W-1:0] slot;
        logic [PIN_W-1:0]  mask;
    } pin_op_t;

endpackage

`default_nettype wire

// File: rtl/core/gpo_owner_table.sv
// Owner slot table: claim, release, owned-pin lookup and change notification.
`timescale 1ns / 1ps
`default_nettype none

module gpo_owner_table (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire gpo_pkg::pin_op_t                 op,
    input  wire logic [gpo_pkg::PIN_W-1:0]        changed,
    output logic      [gpo_pkg::PIN_W-1:0]        owned,
    output gpo_pkg::status_t                      claim_status,
    output logic      [gpo_pkg::SLOT_W-1:0]       granted_slot,
    output logic      [gpo_pkg::NOTIFY_W-1:0]     notify
);

    logic [gpo_pkg::PIN_W-1:0]      owner_pins_reg [gpo_pkg::SLOT_COUNT];
    logic [gpo_pkg::PIN_W-1:0]      owner_pins_next [gpo_pkg::SLOT_COUNT];
    logic [gpo_pkg::SLOT_COUNT-1:0] owner_valid_reg;
    logic [gpo_pkg::SLOT_COUNT-1:0] owner_valid_next;
    logic [gpo_pkg::PIN_W-1:0]      claimed_pins_reg;
    logic [gpo_pkg::PIN_W-1:0]      claimed_pins_next;
    logic                           free_found;
    logic [gpo_pkg::SLOT_W-1:0]     free_slot;

    // Owned pins of the addressed slot; absent or unclaimed slots own nothing
    always_comb
    begin
        owned = '0;
        for (int i = 0; i < gpo_pkg::SLOT_COUNT; i++)
        begin
            if (op.slot == gpo_pkg::SLOT_W'(i) && owner_valid_reg[i])
            begin
                owned = owner_pins_reg[i];
            end
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = gpo_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!owner_valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = gpo_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        notify = '0;
        for (int i = 0; i < gpo_pkg::SLOT_COUNT; i++)
        begin
            notify[i] = owner_valid_reg[i] && ((owner_pins_reg[i] & changed) != '0);
        end
    end

    always_comb
    begin
        owner_pins_next   = owner_pins_reg;
        owner_valid_next  = owner_valid_reg;
        claimed_pins_next = claimed_pins_reg;
        claim_status      = gpo_pkg::ST_OK;
        granted_slot      = '0;
        case (op.func)
            gpo_pkg::FN_CLAIM:
            begin
                if (op.mask == '0 || (op.mask & claimed_pins_reg) != '0)
                begin
                    claim_status = gpo_pkg::ST_TAKEN;
                end
                else if (!free_found)
                begin
                    claim_status = gpo_pkg::ST_NO_SLOT;
                end
                else
                begin
                    granted_slot      = free_slot;
                    claimed_pins_next = claimed_pins_reg | op.mask;
                    for (int i = 0; i < gpo_pkg::SLOT_COUNT; i++)
                    begin
                        if (free_slot == gpo_pkg::SLOT_W'(i))
                        begin
                            owner_valid_next[i] = 1'b1;
                            owner_pins_next[i]  = op.mask;
                        end
                    end
                end
            end
            gpo_pkg::FN_RELEASE:
            begin
                claimed_pins_next = claimed_pins_reg & ~owned;
                for (int i = 0; i < gpo_pkg::SLOT_COUNT; i++)
                begin
                    if (op.slot == gpo_pkg::SLOT_W'(i))
                    begin
                        owner_valid_next[i] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg  <= '0;
            claimed_pins_reg <= '0;
        end
        else if (op.accept)
        begin
            owner_valid_reg  <= owner_valid_next;
            claimed_pins_reg <= claimed_pins_next;
        end
    end

    // Pin masks are only read through the valid bits
    always_ff @(posedge clk)
    begin
        if (op.accept)
        begin
            owner_pins_reg <= owner_pins_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gpo_pin_regs.sv
// Direction, drive and last-known port levels with interrupt mask derivation.
`timescale 1ns / 1ps
`default_nettype none

module gpo_pin_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gpo_pkg::pin_op_t                  op,
    input  wire logic [gpo_pkg::PIN_W-1:0]         owned,
    input  wire logic [1:0]                        port_number,
    input  wire logic [gpo_pkg::PORT_W-1:0]        port_value,
    output logic      [gpo_pkg::PIN_W-1:0]         changed,
    output logic      [gpo_pkg::PIN_W-1:0]         direction_next,
    output logic      [gpo_pkg::PIN_W-1:0]         drive_next,
    output logic      [gpo_pkg::PIN_W-1:0]         drive_now,
    output logic      [gpo_pkg::PIN_W-1:0]         int_mask_next,
    output logic      [gpo_pkg::PORTS_MAX-1:0]     port_en_next
);

    logic [gpo_pkg::PIN_W-1:0]  direction_reg;
    logic [gpo_pkg::PIN_W-1:0]  drive_reg;
    logic [gpo_pkg::PORT_W-1:0] last_levels_reg [gpo_pkg::PORT_COUNT];
    logic [gpo_pkg::PIN_W-1:0]  clean;
    logic [gpo_pkg::PIN_W-1:0]  owned_present;
    logic                       sample;

    assign owned_present = owned & gpo_pkg::PRESENT_PINS;
    assign clean         = op.mask & owned_present;
    assign sample        = (op.func == gpo_pkg::FN_SAMPLE);
    assign drive_now     = drive_reg;

    always_comb
    begin
        changed = '0;
        for (int p = 0; p < gpo_pkg::PORT_COUNT; p++)
        begin
            if (sample && port_number == 2'(p))
            begin
                changed[p*gpo_pkg::PORT_W +: gpo_pkg::PORT_W] = port_value ^ last_levels_reg[p];
            end
        end
    end

    always_comb
    begin
        direction_next = direction_reg;
        drive_next     = drive_reg;
        case (op.func)
            gpo_pkg::FN_INPUT:    direction_next = direction_reg & ~clean;
            gpo_pkg::FN_OUTPUT:   direction_next = direction_reg | clean;
            gpo_pkg::FN_HIGH:     drive_next     = drive_reg | clean;
            gpo_pkg::FN_LOW:      drive_next     = drive_reg & ~clean;
            gpo_pkg::FN_TOGGLE:   drive_next     = drive_reg ^ clean;
            gpo_pkg::FN_WRITE:    drive_next     = (drive_reg & ~owned_present) | clean;
            gpo_pkg::FN_TRISTATE:
            begin
                drive_next     = drive_reg & ~owned;
                direction_next = direction_reg & ~owned;
            end
            default:
            begin
            end
        endcase
    end

    // Watch every input pin; enable a port while any of its pins is an input
    always_comb
    begin
        int_mask_next = ~direction_next & gpo_pkg::PRESENT_PINS;
        for (int p = 0; p < gpo_pkg::PORTS_MAX; p++)
        begin
            port_en_next[p] = |int_mask_next[p*gpo_pkg::PORT_W +: gpo_pkg::PORT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= '0;
            drive_reg     <= '0;
            for (int p = 0; p < gpo_pkg::PORT_COUNT; p++)
            begin
                last_levels_reg[p] <= '0;
            end
        end
        else if (op.accept)
        begin
            direction_reg <= direction_next;
            drive_reg     <= drive_next;
            for (int p = 0; p < gpo_pkg::PORT_COUNT; p++)
            begin
                if (sample && port_number == 2'(p))
                begin
                    last_levels_reg[p] <= port_value;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gpio_pin_owner_controller.sv
// Top level of the GPIO pin owner controller.
//
// Usage:
//   One item on the input channel (in_valid / in_ready) carries an operation
//   code, an owner slot, a pin mask, a port sample and the pin levels. Each
//   item yields exactly one result item on the output channel (out_valid /
//   out_ready): claim status, granted slot, read data, notify mask and the
//   pin direction, drive and interrupt mask views after the operation.
//   The result is registered at the edge that accepts the item. Throughput
//   is one item per cycle while the receiver does not stall; the owner
//   table lookup and the masked register update all settle between the
//   input ports and the result register.
//   If the receiver stalls, the result register holds its item and in_ready
//   drops until it is taken; in_ready is high again in the cycle the result
//   is consumed, so a new item enters as the old one leaves.
//   Reset clears all ownership, sets every pin to input with drive low,
//   clears the last-known port levels and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module gpio_pin_owner_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  func,
    input  wire logic [2:0]  slot,
    input  wire logic [31:0] pin_mask,
    input  wire logic [1:0]  port_number,
    input  wire logic [7:0]  port_value,
    input  wire logic [31:0] pin_levels,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [2:0]       granted_slot,
    output logic [31:0]      read_data,
    output logic [7:0]       notify_mask,
    output logic [31:0]      direction_bits,
    output logic [31:0]      drive_bits,
    output logic [31:0]      change_int_mask,
    output logic [3:0]       port_int_enable
);

    gpo_pkg::pin_op_t op;
    logic [31:0]      owned;
    logic [31:0]      changed;
    gpo_pkg::status_t claim_status;
    logic [2:0]       claim_slot;
    logic [7:0]       notify;
    logic [31:0]      direction_next;
    logic [31:0]      drive_next;
    logic [31:0]      drive_now;
    logic [31:0]      int_mask_next;
    logic [3:0]       port_en_next;
    logic [31:0]      read_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [2:0]  granted_reg;
    logic [31:0] read_reg;
    logic [7:0]  notify_reg;
    logic [31:0] direction_out_reg;
    logic [31:0] drive_out_reg;
    logic [31:0] int_mask_reg;
    logic [3:0]  port_en_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign op.accept = in_valid && in_ready;
    assign op.func   = gpo_pkg::func_t'(func);
    assign op.slot   = slot;
    assign op.mask   = pin_mask;

    gpo_owner_table u_owner_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .changed      (changed),
        .owned        (owned),
        .claim_status (claim_status),
        .granted_slot (claim_slot),
        .notify       (notify)
    );

    gpo_pin_regs u_pin_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .owned          (owned),
        .port_number    (port_number),
        .port_value     (port_value),
        .changed        (changed),
        .direction_next (direction_next),
        .drive_next     (drive_next),
        .drive_now      (drive_now),
        .int_mask_next  (int_mask_next),
        .port_en_next   (port_en_next)
    );

    always_comb
    begin
        case (op.func)
            gpo_pkg::FN_READ_IN:    read_next = pin_levels & owned;
            gpo_pkg::FN_READ_DRIVE: read_next = drive_now & owned;
            gpo_pkg::FN_OWNED:      read_next = owned;
            default:                read_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Load the result alongside the state update
    always_ff @(posedge clk)
    begin
        if (op.accept)
        begin
            status_reg        <= claim_status;
            granted_reg       <= claim_slot;
            read_reg          <= read_next;
            notify_reg        <= notify;
            direction_out_reg <= direction_next;
            drive_out_reg     <= drive_next;
            int_mask_reg      <= int_mask_next;
            port_en_reg       <= port_en_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_slot    = granted_reg;
    assign read_data       = read_reg;
    assign notify_mask     = notify_reg;
    assign direction_bits  = direction_out_reg;
    assign drive_bits      = drive_out_reg;
    assign change_int_mask = int_mask_reg;
    assign port_int_enable = port_en_reg;

endmodule

`default_nettype wire

// File: rtl/core/gpo_checker.sv
// Port-level checks for the GPIO pin owner controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gpo_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [2:0]  granted_slot,
    input wire logic [31:0] direction_bits,
    input wire logic [31:0] change_int_mask,
    input wire logic [3:0]  port_int_enable
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(direction_bits))
        else $error("stalled result changed");

    // A refused claim grants no slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != gpo_pkg::ST_OK |-> granted_slot == 3'd0)
        else $error("slot granted on refused claim");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == gpo_pkg::ST_OK || status == gpo_pkg::ST_TAKEN
            || status == gpo_pkg::ST_NO_SLOT)
        else $error("undefined status code");

    // Interrupt mask holds no output pin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (change_int_mask & direction_bits) == 32'd0)
        else $error("output pin in interrupt mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> port_int_enable[0] == (change_int_mask[7:0] != 8'd0)
            && port_int_enable[1] == (change_int_mask[15:8] != 8'd0)
            && port_int_enable[2] == (change_int_mask[23:16] != 8'd0)
            && port_int_enable[3] == (change_int_mask[31:24] != 8'd0))
        else $error("port enable disagrees with interrupt mask");

endmodule

bind gpio_pin_owner_controller gpo_checker u_gpo_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_slot    (granted_slot),
    .direction_bits  (direction_bits),
    .change_int_mask (change_int_mask),
    .port_int_enable (port_int_enable)
);

`default_nettype wire

// File: tb/gpio_owner_checker.sv
// Result checker for the GPIO pin owner controller: predicts every result and compares it.
`timescale 1ns / 1ps

module gpio_owner_checker
    import gpo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [3:0]  func,
    input  wire logic [2:0]  slot,
    input  wire logic [31:0] pin_mask,
    input  wire logic [1:0]  port_number,
    input  wire logic [7:0]  port_value,
    input  wire logic [31:0] pin_levels,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  status,
    input  wire logic [2:0]  granted_slot,
    input  wire logic [31:0] read_data,
    input  wire logic [7:0]  notify_mask,
    input  wire logic [31:0] direction_bits,
    input  wire logic [31:0] drive_bits,
    input  wire logic [31:0] change_int_mask,
    input  wire logic [3:0]  port_int_enable,
    output int               mismatch_count,
    output int               pending_count,
    output int               checked_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  granted;
        logic [31:0] rdata;
        logic [7:0]  notify;
        logic [31:0] dir;
        logic [31:0] drive;
        logic [31:0] watch;
        logic [3:0]  port_en;
    } pin_view_t;

    logic [31:0] slot_pins_tbl [0:7];
    logic [7:0]  slot_live;
    logic [31:0] taken_pins;
    logic [31:0] dir_shadow;
    logic [31:0] drive_shadow;
    logic [7:0]  port_levels_seen [0:3];
    pin_view_t   awaited_views [$];
    int          errors;
    int          compared;

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    task automatic compare_view(input pin_view_t want, input pin_view_t got);
        if (want.status !== got.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
        if (want.granted !== got.granted)
            note_mismatch("granted_slot", 32'(want.granted), 32'(got.granted));
        if (want.rdata !== got.rdata)
            note_mismatch("read_data", want.rdata, got.rdata);
        if (want.notify !== got.notify)
            note_mismatch("notify_mask", 32'(want.notify), 32'(got.notify));
        if (want.dir !== got.dir)
            note_mismatch("direction_bits", want.dir, got.dir);
        if (want.drive !== got.drive)
            note_mismatch("drive_bits", want.drive, got.drive);
        if (want.watch !== got.watch)
            note_mismatch("change_int_mask", want.watch, got.watch);
        if (want.port_en !== got.port_en)
            note_mismatch("port_int_enable", 32'(want.port_en), 32'(got.port_en));
    endtask

    // Apply one operation to the shadow pin state and build the view it yields
    task automatic predict_pin_op(input logic [3:0] fn, input logic [2:0] sl,
                                  input logic [31:0] mask, input logic [1:0] pn,
                                  input logic [7:0] pv, input logic [31:0] lv,
                                  output pin_view_t v);
        logic [31:0] owned;
        logic [31:0] clean;
        logic [31:0] changed;
        logic        placed;
        v = '0;
        placed = 1'b0;
        if (int'(sl) < SLOT_COUNT && slot_live[sl])
            owned = slot_pins_tbl[sl];
        else
            owned = '0;
        clean = mask & owned & PRESENT_PINS;
        case (fn)
            FN_CLAIM:
            begin
                if (mask == '0 || (mask & taken_pins) != '0)
                begin
                    v.status = ST_TAKEN;
                end
                else
                begin
                    v.status = ST_NO_SLOT;
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (!placed && !slot_live[i])
                        begin
                            slot_live[i]     = 1'b1;
                            slot_pins_tbl[i] = mask;
                            taken_pins       = taken_pins | mask;
                            v.granted        = 3'(i);
                            v.status         = ST_OK;
                            placed           = 1'b1;
                        end
                    end
                end
            end
            FN_RELEASE:
            begin
                if (int'(sl) < SLOT_COUNT && slot_live[sl])
                begin
                    taken_pins        = taken_pins & ~slot_pins_tbl[sl];
                    slot_pins_tbl[sl] = '0;
                    slot_live[sl]     = 1'b0;
                end
            end
            FN_INPUT:      dir_shadow   = dir_shadow & ~clean;
            FN_OUTPUT:     dir_shadow   = dir_shadow | clean;
            FN_HIGH:       drive_shadow = drive_shadow | clean;
            FN_LOW:        drive_shadow = drive_shadow & ~clean;
            FN_TOGGLE:     drive_shadow = drive_shadow ^ clean;
            FN_WRITE:      drive_shadow = (drive_shadow & ~(owned & PRESENT_PINS)) | clean;
            FN_READ_IN:    v.rdata = lv & owned;
            FN_READ_DRIVE: v.rdata = drive_shadow & owned;
            FN_TRISTATE:
            begin
                drive_shadow = drive_shadow & ~owned;
                dir_shadow   = dir_shadow & ~owned;
            end
            FN_SAMPLE:
            begin
                if (int'(pn) < PORT_COUNT)
                begin
                    changed = 32'(pv ^ port_levels_seen[pn]) << (PORT_W * int'(pn));
                    port_levels_seen[pn] = pv;
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (slot_live[i] && (slot_pins_tbl[i] & changed) != '0)
                            v.notify[i] = 1'b1;
                end
            end
            FN_OWNED:      v.rdata = owned;
            default:       ;
        endcase
        v.dir   = dir_shadow;
        v.drive = drive_shadow;
        v.watch = ~dir_shadow & PRESENT_PINS;
        for (int p = 0; p < PORTS_MAX; p++)
            v.port_en[p] = |v.watch[PORT_W*p +: PORT_W];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        pin_view_t seen;
        pin_view_t predicted;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                slot_pins_tbl[i] = '0;
            for (int i = 0; i < 4; i++)
                port_levels_seen[i] = '0;
            slot_live    = '0;
            taken_pins   = '0;
            dir_shadow   = '0;
            drive_shadow = '0;
            awaited_views.delete();
            errors   = 0;
            compared = 0;
        end
        else
        begin
            // Results leave before the item accepted at this edge can produce one
            if (out_valid && out_ready)
            begin
                seen.status  = status;
                seen.granted = granted_slot;
                seen.rdata   = read_data;
                seen.notify  = notify_mask;
                seen.dir     = direction_bits;
                seen.drive   = drive_bits;
                seen.watch   = change_int_mask;
                seen.port_en = port_int_enable;
                if (awaited_views.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result item with nothing outstanding", $time);
                end
                else
                begin
                    compare_view(awaited_views.pop_front(), seen);
                    compared++;
                end
            end
            if (in_valid && in_ready)
            begin
                predict_pin_op(func, slot, pin_mask, port_number, port_value, pin_levels,
                               predicted);
                awaited_views.push_back(predicted);
            end
        end
        mismatch_count <= errors;
        pending_count  <= awaited_views.size();
        checked_count  <= compared;
    end

endmodule

// File: tb/gpio_pin_owner_controller_tb.sv
// Testbench top for the GPIO pin owner controller: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module gpio_pin_owner_controller_tb;
    import gpo_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [3:0] FN_SPARE_LO = 4'd13;
    localparam logic [3:0] FN_SPARE_HI = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  func;
    logic [2:0]  slot;
    logic [31:0] pin_mask;
    logic [1:0]  port_number;
    logic [7:0]  port_value;
    logic [31:0] pin_levels;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [2:0]  granted_slot;
    logic [31:0] read_data;
    logic [7:0]  notify_mask;
    logic [31:0] direction_bits;
    logic [31:0] drive_bits;
    logic [31:0] change_int_mask;
    logic [3:0]  port_int_enable;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int items_sent;
    int hold_trigger;
    int cycle_count;
    logic hold_off_req;

    gpio_pin_owner_controller uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .slot            (slot),
        .pin_mask        (pin_mask),
        .port_number     (port_number),
        .port_value      (port_value),
        .pin_levels      (pin_levels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_slot    (granted_slot),
        .read_data       (read_data),
        .notify_mask     (notify_mask),
        .direction_bits  (direction_bits),
        .drive_bits      (drive_bits),
        .change_int_mask (change_int_mask),
        .port_int_enable (port_int_enable)
    );

    gpio_owner_checker owner_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .slot            (slot),
        .pin_mask        (pin_mask),
        .port_number     (port_number),
        .port_value      (port_value),
        .pin_levels      (pin_levels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_slot    (granted_slot),
        .read_data       (read_data),
        .notify_mask     (notify_mask),
        .direction_bits  (direction_bits),
        .drive_bits      (drive_bits),
        .change_int_mask (change_int_mask),
        .port_int_enable (port_int_enable),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offer one item and hold it until the block takes it
    task automatic send_op(input logic [3:0] fn, input logic [2:0] sl,
                           input logic [31:0] mask, input logic [1:0] pn = 2'd0,
                           input logic [7:0] pv = 8'd0, input logic [31:0] lv = 32'd0);
        @(negedge clk);
        in_valid    = 1'b1;
        func        = fn;
        slot        = sl;
        pin_mask    = mask;
        port_number = pn;
        port_value  = pv;
        pin_levels  = lv;
        if (items_sent == hold_trigger)
            hold_off_req = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stop offering until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] claim_pins();
        int lane;
        lane = $urandom_range(0, 31);
        case ($urandom_range(0, 2))
            0:       return 32'd1 << lane;
            1:       return 32'd3 << lane;
            default: return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [31:0] pick_pins();
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
            4:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_op();
        int          pick;
        logic [3:0]  fn;
        logic [31:0] mask;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            fn   = FN_CLAIM;
            mask = claim_pins();
        end
        else if (pick < 30)
        begin
            fn   = FN_RELEASE;
            mask = $urandom;
        end
        else if (pick < 94)
        begin
            fn   = 4'($urandom_range(int'(FN_INPUT), int'(FN_OWNED)));
            mask = pick_pins();
        end
        else if (pick < 98)
        begin
            // claims that mostly collide or are empty
            fn   = FN_CLAIM;
            mask = pick_pins();
        end
        else
        begin
            fn   = 4'($urandom_range(int'(FN_SPARE_LO), int'(FN_SPARE_HI)));
            mask = $urandom;
        end
        send_op(fn, 3'($urandom_range(0, 7)), mask, 2'($urandom_range(0, 3)),
                8'($urandom), $urandom);
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        int   mode;
        int   span;
        logic hold_served;
        out_ready   = 1'b0;
        hold_served = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            for (int step = 0; step < span; step++)
            begin
                @(posedge clk);
                if (hold_off_req && !hold_served)
                begin
                    hold_served = 1'b1;
                    @(negedge clk);
                    out_ready = 1'b0;
                    for (int n = 1; n < HOLD_CYCLES; n++)
                        @(negedge clk);
                end
                else
                begin
                    @(negedge clk);
                    case (mode)
                        0:       out_ready = 1'b1;
                        1:       out_ready = ($urandom_range(0, 3) != 0);
                        2:       out_ready = ($urandom_range(0, 3) == 0);
                        default: out_ready = ((step % 6) < 2);
                    endcase
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, pending_count);
        $display("gpio_pin_owner_controller_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int   sent_random;
        int   burst;
        int   directed_items;
        logic drained_mid;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = '0;
        slot         = '0;
        pin_mask     = '0;
        port_number  = '0;
        port_value   = '0;
        pin_levels   = '0;
        hold_off_req = 1'b0;
        items_sent   = 0;
        hold_trigger = -1;
        sent_random  = 0;
        drained_mid  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty claim, fill every slot, no free slot, overlap
        send_op(FN_CLAIM, 3'd0, 32'h0);
        for (int k = 0; k < 8; k++)
            send_op(FN_CLAIM, 3'd0, 32'h7 << (4 * k));
        send_op(FN_CLAIM, 3'd0, 32'h0000_0008);
        send_op(FN_CLAIM, 3'd7, 32'hFFFF_FFFF);
        // lowest free slot goes back out after a release
        send_op(FN_RELEASE, 3'd5, 32'h0);
        send_op(FN_CLAIM, 3'd0, 32'h8000_0008);
        send_op(FN_OUTPUT, 3'd0, 32'hFFFF_FFFF);
        send_op(FN_HIGH, 3'd0, 32'hFFFF_FFFF);
        send_op(FN_TOGGLE, 3'd7, 32'hFFFF_FFFF);
        send_op(FN_WRITE, 3'd5, 32'h8000_0000);
        send_op(FN_READ_IN, 3'd1, 32'h0, 2'd0, 8'd0, 32'hFFFF_FFFF);
        send_op(FN_READ_DRIVE, 3'd0, 32'h0);
        send_op(FN_OWNED, 3'd7, 32'h0);
        send_op(FN_SAMPLE, 3'd0, 32'h0, 2'd0, 8'hFF);
        send_op(FN_SAMPLE, 3'd0, 32'h0, 2'd3, 8'h80);
        send_op(FN_LOW, 3'd0, 32'hFFFF_FFFF);
        send_op(FN_TRISTATE, 3'd0, 32'h0);
        // unclaimed slot owns nothing
        send_op(FN_RELEASE, 3'd3, 32'h0);
        send_op(FN_OWNED, 3'd3, 32'hFFFF_FFFF);
        send_op(FN_SPARE_HI, 3'd7, 32'hFFFF_FFFF, 2'd3, 8'hFF, 32'hFFFF_FFFF);
        directed_items = items_sent;
        drain_results();

        // Random bursts; one long receiver hold-off and one full drain on the way
        hold_trigger = items_sent + RANDOM_ITEMS / 3;
        while (sent_random < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent_random < RANDOM_ITEMS; b++)
            begin
                send_random_op();
                sent_random++;
            end
            if (!drained_mid && sent_random >= (2 * RANDOM_ITEMS) / 3)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 8));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d operations (%0d directed) with %0d results compared",
                 items_sent, directed_items, checked_count);
        $display("through a full owner table, a long receiver hold-off and a mid-run drain.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("gpio_pin_owner_controller_tb: clean");
        else
            $display("gpio_pin_owner_controller_tb: errors");
        $finish;
    end

endmodule
